FILE: rtl/binned_pair_statistics_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binned pair statistics block
// Implication checks on a clock with an active-low reset, in two forms:
// same-cycle and next-cycle.
// ----------------------------------------------------------------------------
`ifndef BINNED_PAIR_STATISTICS_ASSERT_SVH
`define BINNED_PAIR_STATISTICS_ASSERT_SVH

`ifndef ASSERT_OFF

`define BPS_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define BPS_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BPS_ASSERT_IMP(name, clk, rstn, ante, cons)

`define BPS_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Types and constants shared by the binned pair statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

    localparam int CFG_W     = 22;
    localparam int CFG_IDX_W = 2;
    localparam int FB_W      = 7;
    localparam int OP_W      = 2;
    localparam int VALUE_W   = 22;
    localparam int TRAIT_W   = 16;
    localparam int PRODUCT_W = 32;
    localparam int RBIN_W    = 8;
    localparam int BIN_W     = 8;
    localparam int COUNT_W   = 40;
    localparam int PSUM_W    = 64;
    localparam int VSUM_W    = 62;
    localparam int DIFF_W    = 22;
    localparam int RECIP_W   = 24;
    localparam int BINF_W    = 24;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 176;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_EDGE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_BINS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_EDGE  = 2'd3;

    localparam logic [OP_W-1:0] OP_ACCUM      = 2'd0;
    localparam logic [OP_W-1:0] OP_READ       = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;

    localparam logic [CFG_W-1:0] LOW_EDGE_RST   = 22'(-300000);
    localparam logic [CFG_W-1:0] FINE_START_RST = 22'(-20000);
    localparam logic [FB_W-1:0]  FINE_BINS_RST  = 7'd40;
    localparam logic [CFG_W-1:0] HIGH_EDGE_RST  = 22'(1050000);

    localparam logic [PSUM_W-1:0] PSUM_MAX = {1'b0, {(PSUM_W-1){1'b1}}};
    localparam logic [PSUM_W-1:0] PSUM_MIN = {1'b1, {(PSUM_W-1){1'b0}}};
    localparam logic [VSUM_W-1:0] VSUM_MAX = {1'b0, {(VSUM_W-1){1'b1}}};
    localparam logic [VSUM_W-1:0] VSUM_MIN = {1'b1, {(VSUM_W-1){1'b0}}};

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [PSUM_W-1:0]  psum;
        logic [VSUM_W-1:0]  vsum;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIFF,
        ST_RECIP,
        ST_CORRECT,
        ST_BIN,
        ST_READ,
        ST_WRITE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/binned_pair_statistics.sv
// ----------------------------------------------------------------------------
// binned_pair_statistics
// Per-bin count, trait product sum and relationship value sum in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per operation. s_tuser holds the op code (accumulate,
//   read, read and clear); s_tdata holds the value, both traits and the bin
//   to read. m_ channel: one result word per input word, in order.
//   cfg_we/cfg_index/cfg_wdata write the four bin edge registers; write them
//   only while no word is in flight.
//   An accepted word is worked on by a sequencer: offset, reciprocal
//   multiply, quotient correction, bin select, memory read and write-back.
//   A new word is taken only once the previous one has passed through all
//   seven sequencer steps, the idle step included, and the result is
//   registered at write-back.
//   After reset a clearing pass writes zero to all MAX_BINS entries, one per
//   cycle, before the first word is taken.
//   The result sits in an output register, so the next word is accepted while
//   it waits; a stalled receiver holds the block in write-back until the
//   register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module binned_pair_statistics #(
    parameter int MAX_BINS     = 256,
    parameter int FINE_WIDTH   = 1000,
    parameter int COARSE_WIDTH = 5000
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             cfg_we,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bps_pkg::CFG_W-1:0]        cfg_wdata,

    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // grm_value[21:0], y_first[37:22], y_second[53:38], read_bin[61:54]
    input  wire logic [bps_pkg::S_TDATA_W-1:0]    s_tdata,
    // op[1:0]
    input  wire logic [bps_pkg::OP_W-1:0]         s_tuser,

    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // bin_index[7:0], pair_count[47:8], product_total[111:48],
    // value_total[173:112]
    output logic [bps_pkg::M_TDATA_W-1:0]         m_tdata,
    // in_range[0]
    output logic [0:0]                            m_tuser
);

    localparam int ADDR_W       = $clog2(MAX_BINS);
    localparam int FINE_SHIFT   = bps_pkg::DIFF_W + $clog2(FINE_WIDTH);
    localparam int COARSE_SHIFT = bps_pkg::DIFF_W + $clog2(COARSE_WIDTH);
    localparam logic [bps_pkg::RECIP_W-1:0] FINE_RECIP =
        bps_pkg::RECIP_W'((64'd1 << FINE_SHIFT) / FINE_WIDTH);
    localparam logic [bps_pkg::RECIP_W-1:0] COARSE_RECIP =
        bps_pkg::RECIP_W'((64'd1 << COARSE_SHIFT) / COARSE_WIDTH);
    localparam int MUL_W = bps_pkg::DIFF_W + bps_pkg::RECIP_W;
    localparam int REM_W = 40;

    // configuration
    logic signed [bps_pkg::CFG_W-1:0] low_edge_reg;
    logic signed [bps_pkg::CFG_W-1:0] fine_start_reg;
    logic [bps_pkg::FB_W-1:0]         fine_bins_reg;
    logic signed [bps_pkg::CFG_W-1:0] high_edge_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_edge_reg   <= bps_pkg::LOW_EDGE_RST;
            fine_start_reg <= bps_pkg::FINE_START_RST;
            fine_bins_reg  <= bps_pkg::FINE_BINS_RST;
            high_edge_reg  <= bps_pkg::HIGH_EDGE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                bps_pkg::REG_LOW_EDGE:   low_edge_reg   <= cfg_wdata;
                bps_pkg::REG_FINE_START: fine_start_reg <= cfg_wdata;
                bps_pkg::REG_FINE_BINS:  fine_bins_reg  <= cfg_wdata[bps_pkg::FB_W-1:0];
                bps_pkg::REG_HIGH_EDGE:  high_edge_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    bps_pkg::state_t     state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                out_free;
    logic                out_load;
    logic                rd_en;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    bps_pkg::entry_t     mem_wdata;
    logic                accept;

    // captured word
    logic [bps_pkg::OP_W-1:0]           op_reg;
    logic signed [bps_pkg::VALUE_W-1:0] grm_reg;
    logic signed [bps_pkg::TRAIT_W-1:0] y_first_reg;
    logic signed [bps_pkg::TRAIT_W-1:0] y_second_reg;
    logic [bps_pkg::RBIN_W-1:0]         rbin_reg;

    // datapath stages
    logic [31:0]                          coarse_start;
    logic [31:0]                          coarse_full;
    logic [bps_pkg::DIFF_W:0]             fine_full;
    logic [bps_pkg::DIFF_W-1:0]           fine_diff_reg, coarse_diff_reg;
    logic                                 below_low_reg, at_high_reg, below_fine_reg;
    logic signed [bps_pkg::PRODUCT_W-1:0] prod_reg;
    logic [MUL_W-1:0]                     fine_mul, coarse_mul;
    logic [bps_pkg::DIFF_W-1:0]           fine_est_reg, coarse_est_reg;
    logic [REM_W-1:0]                     fine_rem, coarse_rem;
    logic [bps_pkg::DIFF_W-1:0]           fine_q_reg, coarse_q_reg;
    logic [bps_pkg::BINF_W-1:0]           bin_next, bin_reg;
    logic                                 in_range_next, in_range_reg;

    // memory
    bps_pkg::entry_t mem [MAX_BINS];
    bps_pkg::entry_t rd_entry_reg;

    // write-back
    logic [bps_pkg::COUNT_W-1:0] count_new;
    logic [bps_pkg::PSUM_W:0]    psum_wide;
    logic [bps_pkg::PSUM_W-1:0]  psum_new;
    logic [bps_pkg::VSUM_W:0]    vsum_wide;
    logic [bps_pkg::VSUM_W-1:0]  vsum_new;
    logic                        is_accum;

    logic [bps_pkg::BIN_W-1:0]   out_bin_reg, out_bin_next;
    logic                        out_in_range_reg;
    logic [bps_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic [bps_pkg::PSUM_W-1:0]  out_psum_reg, out_psum_next;
    logic [bps_pkg::VSUM_W-1:0]  out_vsum_reg, out_vsum_next;

    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_accum = (op_reg == bps_pkg::OP_ACCUM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bps_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        s_tready      = 1'b0;
        rd_en         = 1'b0;
        out_load      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = bin_reg[ADDR_W-1:0];
        mem_wdata     = '0;
        case (state_reg)
            bps_pkg::ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(MAX_BINS - 1)) begin
                    state_next = bps_pkg::ST_IDLE;
                end
            end
            bps_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = bps_pkg::ST_DIFF;
                end
            end
            bps_pkg::ST_DIFF:    state_next = bps_pkg::ST_RECIP;
            bps_pkg::ST_RECIP:   state_next = bps_pkg::ST_CORRECT;
            bps_pkg::ST_CORRECT: state_next = bps_pkg::ST_BIN;
            bps_pkg::ST_BIN:     state_next = bps_pkg::ST_READ;
            bps_pkg::ST_READ: begin
                rd_en      = 1'b1;
                state_next = bps_pkg::ST_WRITE;
            end
            bps_pkg::ST_WRITE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = bps_pkg::ST_IDLE;
                    if (in_range_reg && is_accum) begin
                        mem_we    = 1'b1;
                        mem_wdata = '{count: count_new, psum: psum_new, vsum: vsum_new};
                    end else if (in_range_reg && op_reg == bps_pkg::OP_READ_CLEAR) begin
                        mem_we = 1'b1;
                    end
                end
            end
            default: state_next = bps_pkg::ST_IDLE;
        endcase
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= s_tuser;
            grm_reg      <= s_tdata[21:0];
            y_first_reg  <= s_tdata[37:22];
            y_second_reg <= s_tdata[53:38];
            rbin_reg     <= s_tdata[61:54];
        end
    end

    // offsets from the first fine bin edge and from the first coarse bin
    assign fine_full    = {grm_reg[bps_pkg::VALUE_W-1], grm_reg}
                        - {fine_start_reg[bps_pkg::CFG_W-1], fine_start_reg};
    assign coarse_start = {{(32-bps_pkg::CFG_W){fine_start_reg[bps_pkg::CFG_W-1]}},
                           fine_start_reg}
                        + 32'(fine_bins_reg) * 32'(FINE_WIDTH);
    assign coarse_full  = {{(32-bps_pkg::VALUE_W){grm_reg[bps_pkg::VALUE_W-1]}}, grm_reg}
                        - coarse_start;

    // quotient estimate, low by at most one
    assign fine_mul   = MUL_W'(fine_diff_reg) * MUL_W'(FINE_RECIP);
    assign coarse_mul = MUL_W'(coarse_diff_reg) * MUL_W'(COARSE_RECIP);

    assign fine_rem   = REM_W'(fine_diff_reg)
                      - REM_W'(fine_est_reg) * REM_W'(FINE_WIDTH);
    assign coarse_rem = REM_W'(coarse_diff_reg)
                      - REM_W'(coarse_est_reg) * REM_W'(COARSE_WIDTH);

    always_comb begin
        if (is_accum) begin
            if (below_fine_reg) begin
                bin_next = '0;
            end else if (fine_q_reg < bps_pkg::DIFF_W'(fine_bins_reg)) begin
                bin_next = bps_pkg::BINF_W'(fine_q_reg) + bps_pkg::BINF_W'(1);
            end else begin
                bin_next = bps_pkg::BINF_W'(coarse_q_reg)
                         + bps_pkg::BINF_W'(fine_bins_reg) + bps_pkg::BINF_W'(1);
            end
            in_range_next = !below_low_reg && !at_high_reg
                         && (bin_next < bps_pkg::BINF_W'(MAX_BINS));
        end else begin
            bin_next      = bps_pkg::BINF_W'(rbin_reg);
            in_range_next = bin_next < bps_pkg::BINF_W'(MAX_BINS);
        end
    end

    always_ff @(posedge aclk) begin
        fine_diff_reg   <= fine_full[bps_pkg::DIFF_W-1:0];
        coarse_diff_reg <= coarse_full[bps_pkg::DIFF_W-1:0];
        below_low_reg   <= grm_reg < low_edge_reg;
        at_high_reg     <= grm_reg >= high_edge_reg;
        below_fine_reg  <= grm_reg < fine_start_reg;
        prod_reg        <= y_first_reg * y_second_reg;
        fine_est_reg    <= bps_pkg::DIFF_W'(fine_mul >> FINE_SHIFT);
        coarse_est_reg  <= bps_pkg::DIFF_W'(coarse_mul >> COARSE_SHIFT);
        fine_q_reg      <= fine_est_reg
                         + bps_pkg::DIFF_W'(fine_rem >= REM_W'(FINE_WIDTH));
        coarse_q_reg    <= coarse_est_reg
                         + bps_pkg::DIFF_W'(coarse_rem >= REM_W'(COARSE_WIDTH));
        bin_reg         <= bin_next;
        in_range_reg    <= in_range_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_entry_reg <= mem[bin_reg[ADDR_W-1:0]];
        end
    end

    // saturating updates
    assign count_new = (&rd_entry_reg.count) ? rd_entry_reg.count
                     : rd_entry_reg.count + bps_pkg::COUNT_W'(1);
    assign psum_wide = {rd_entry_reg.psum[bps_pkg::PSUM_W-1], rd_entry_reg.psum}
                     + {{(bps_pkg::PSUM_W+1-bps_pkg::PRODUCT_W){prod_reg[bps_pkg::PRODUCT_W-1]}},
                        prod_reg};
    assign psum_new  = (psum_wide[bps_pkg::PSUM_W] != psum_wide[bps_pkg::PSUM_W-1])
                     ? (psum_wide[bps_pkg::PSUM_W] ? bps_pkg::PSUM_MIN : bps_pkg::PSUM_MAX)
                     : psum_wide[bps_pkg::PSUM_W-1:0];
    assign vsum_wide = {rd_entry_reg.vsum[bps_pkg::VSUM_W-1], rd_entry_reg.vsum}
                     + {{(bps_pkg::VSUM_W+1-bps_pkg::VALUE_W){grm_reg[bps_pkg::VALUE_W-1]}},
                        grm_reg};
    assign vsum_new  = (vsum_wide[bps_pkg::VSUM_W] != vsum_wide[bps_pkg::VSUM_W-1])
                     ? (vsum_wide[bps_pkg::VSUM_W] ? bps_pkg::VSUM_MIN : bps_pkg::VSUM_MAX)
                     : vsum_wide[bps_pkg::VSUM_W-1:0];

    always_comb begin
        out_bin_next   = is_accum ? '0 : rbin_reg;
        out_count_next = '0;
        out_psum_next  = '0;
        out_vsum_next  = '0;
        if (in_range_reg) begin
            out_bin_next = bin_reg[bps_pkg::BIN_W-1:0];
            if (is_accum) begin
                out_count_next = count_new;
                out_psum_next  = psum_new;
                out_vsum_next  = vsum_new;
            end else begin
                out_count_next = rd_entry_reg.count;
                out_psum_next  = rd_entry_reg.psum;
                out_vsum_next  = rd_entry_reg.vsum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_bin_reg      <= out_bin_next;
            out_in_range_reg <= in_range_reg;
            out_count_reg    <= out_count_next;
            out_psum_reg     <= out_psum_next;
            out_vsum_reg     <= out_vsum_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_vsum_reg, out_psum_reg, out_count_reg, out_bin_reg};
    assign m_tuser  = out_in_range_reg;

    `include "binned_pair_statistics_assert.svh"

    `BPS_ASSERT_IMP(a_mem_we_state, aclk, aresetn, mem_we,
        state_reg == bps_pkg::ST_CLEAR || state_reg == bps_pkg::ST_WRITE)

    `BPS_ASSERT_IMP(a_no_take_in_clear, aclk, aresetn,
        state_reg == bps_pkg::ST_CLEAR, !s_tready)

    `BPS_ASSERT_IMP(a_miss_is_zero, aclk, aresetn, m_tvalid && !m_tuser[0],
        out_count_reg == '0 && out_psum_reg == '0 && out_vsum_reg == '0)

    `BPS_ASSERT_NXT(a_load_from_write, aclk, aresetn, out_load,
        m_tvalid && $past(state_reg) == bps_pkg::ST_WRITE)

endmodule

`default_nettype wire
